/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TCWE_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("tcwe assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define TCWE_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("tcwe forbidden condition seen");

`endif

/* rtl/core/tcwe_pkg.sv */
`timescale 1ns / 1ps
package tcwe_pkg;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  localparam logic [31:0] MS_PER_S = 32'd1000;

  typedef struct packed {
    logic        req_type;
    logic [63:0] host_key;
    logic [7:0]  ticket_kind;
    logic [31:0] lifetime_s;
    logic [31:0] now_s;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        was_expired;
    logic        evicted;
    logic [2:0]  slot_index;
    logic [7:0]  kind_out;
    logic [31:0] age_ms;
  } rsp_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic        active;
    logic        get;
    logic        found;
    logic        expired;
    logic        free_found;
    logic        old_found;
    logic [31:0] age;
    logic [31:0] old_stamp;
    logic [7:0]  kind;
  } tok_t;

  typedef struct packed {
    logic        en;
    logic [63:0] key;
    logic [7:0]  kind;
    logic [31:0] stamp;
    logic [31:0] life;
  } wr_t;

endpackage

/* rtl/core/ticket_cache_with_expiry_top.sv */
// A transaction's result passes through the launch register, the ENTRIES cell
// registers, the finish register and the response register. The search token walks
// the chain of ENTRIES cells one cell per cycle; one transaction is in flight at once.
// Reset (rst, synchronous, active high) empties every slot and drops any transaction
// in flight; the table is usable as soon as reset is released.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ticket_cache_with_expiry_top #(
  parameter int ENTRIES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tcwe_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tcwe_pkg::rsp_t rsp_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic           busy;
  logic           launch;
  tcwe_pkg::req_t req_q;

  tcwe_pkg::tok_t   tok       [ENTRIES+1];
  logic [IDX_W-1:0] found_idx [ENTRIES+1];
  logic [IDX_W-1:0] free_idx  [ENTRIES+1];
  logic [IDX_W-1:0] old_idx   [ENTRIES+1];
  logic [ENTRIES-1:0] tok_act;
  logic [ENTRIES:0]   tok_busy_vec;

  tcwe_pkg::wr_t    wr;
  logic [IDX_W-1:0] put_slot;
  logic [IDX_W-1:0] res_slot;
  logic [IDX_W+2:0] res_slot_wide;
  tcwe_pkg::tok_t   tl;
  logic             res_hit;

  logic        fin_valid;
  logic        fin_hit;
  logic        fin_exp;
  logic        fin_ev;
  logic [2:0]  fin_slot;
  logic [7:0]  fin_kind;
  logic [31:0] fin_age;
  logic        fin_move;

  assign req_ready = !busy;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = launch;
    tok[0].get    = (req_q.req_type == tcwe_pkg::REQ_GET);
    found_idx[0]  = '0;
    free_idx[0]   = '0;
    old_idx[0]    = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tcwe_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .host_key      (req_q.host_key),
      .now_s         (req_q.now_s),
      .tok_in        (tok[g]),
      .found_idx_in  (found_idx[g]),
      .free_idx_in   (free_idx[g]),
      .old_idx_in    (old_idx[g]),
      .tok_out       (tok[g+1]),
      .found_idx_out (found_idx[g+1]),
      .free_idx_out  (free_idx[g+1]),
      .old_idx_out   (old_idx[g+1]),
      .wr            (wr),
      .wr_idx        (put_slot)
    );
    assign tok_act[g] = tok[g+1].active;
  end

  assign tok_busy_vec = {launch, tok_act};

  assign tl = tok[ENTRIES];

  always_comb begin
    if (tl.found) begin
      put_slot = found_idx[ENTRIES];
    end else if (tl.free_found) begin
      put_slot = free_idx[ENTRIES];
    end else begin
      put_slot = old_idx[ENTRIES];
    end
  end

  assign wr.en    = tl.active && !tl.get;
  assign wr.key   = req_q.host_key;
  assign wr.kind  = req_q.ticket_kind;
  assign wr.stamp = req_q.now_s;
  assign wr.life  = req_q.lifetime_s;

  assign res_hit       = tl.get && tl.found && !tl.expired;
  assign res_slot      = !tl.get ? put_slot : (tl.found ? found_idx[ENTRIES] : '0);
  assign res_slot_wide = {3'b000, res_slot};

  assign fin_move = fin_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      launch    <= 1'b0;
      fin_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      launch <= req_valid && req_ready;
      if (req_valid && req_ready) begin
        busy <= 1'b1;
      end else if (fin_move) begin
        busy <= 1'b0;
      end
      if (tl.active) begin
        fin_valid <= 1'b1;
      end else if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (fin_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req_data;
    end
    if (tl.active) begin
      fin_hit  <= res_hit;
      fin_exp  <= tl.get && tl.found && tl.expired;
      fin_ev   <= !tl.get && !tl.found && !tl.free_found;
      fin_slot <= res_slot_wide[2:0];
      fin_kind <= res_hit ? tl.kind : 8'd0;
      fin_age  <= res_hit ? tl.age : 32'd0;
    end
    if (fin_move) begin
      rsp_data.hit         <= fin_hit;
      rsp_data.was_expired <= fin_exp;
      rsp_data.evicted     <= fin_ev;
      rsp_data.slot_index  <= fin_slot;
      rsp_data.kind_out    <= fin_kind;
      rsp_data.age_ms      <= fin_age * tcwe_pkg::MS_PER_S;
    end
  end

  `TCWE_ASSERT(a_single_token, clk, rst, $onehot0(tok_busy_vec))
  `TCWE_ASSERT(a_accept_when_empty, clk, rst, (req_valid && req_ready) |-> !(fin_valid || (|tok_busy_vec)))
  `TCWE_ASSERT(a_fin_while_busy, clk, rst, fin_valid |-> busy)
  `TCWE_NEVER(a_hit_and_expired, clk, rst, rsp_valid && rsp_data.hit && rsp_data.was_expired)

endmodule

/* rtl/core/tcwe_cell.sv */
`timescale 1ns / 1ps
module tcwe_cell #(
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       host_key,
  input  logic [31:0]       now_s,
  input  tcwe_pkg::tok_t    tok_in,
  input  logic [IDX_W-1:0]  found_idx_in,
  input  logic [IDX_W-1:0]  free_idx_in,
  input  logic [IDX_W-1:0]  old_idx_in,
  output tcwe_pkg::tok_t    tok_out,
  output logic [IDX_W-1:0]  found_idx_out,
  output logic [IDX_W-1:0]  free_idx_out,
  output logic [IDX_W-1:0]  old_idx_out,
  input  tcwe_pkg::wr_t     wr,
  input  logic [IDX_W-1:0]  wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic        valid;
  logic [63:0] key;
  logic [31:0] stamp;
  logic [31:0] life;
  logic [7:0]  kind;

  tcwe_pkg::tok_t   tok_next;
  logic [IDX_W-1:0] found_idx_next;
  logic [IDX_W-1:0] free_idx_next;
  logic [IDX_W-1:0] old_idx_next;

  logic        match;
  logic [31:0] age;
  logic        stale;
  logic        wr_here;

  assign match   = valid && (key == host_key);
  assign age     = now_s - stamp;
  assign stale   = age >= life;
  assign wr_here = wr.en && (wr_idx == MY_IDX);

  always_comb begin
    tok_next       = tok_in;
    found_idx_next = found_idx_in;
    free_idx_next  = free_idx_in;
    old_idx_next   = old_idx_in;
    if (!tok_in.found) begin
      if (match) begin
        tok_next.found   = 1'b1;
        tok_next.expired = stale;
        tok_next.age     = age;
        tok_next.kind    = kind;
        found_idx_next   = MY_IDX;
      end else if (valid) begin
        if (!tok_in.old_found || (stamp < tok_in.old_stamp)) begin
          tok_next.old_found = 1'b1;
          tok_next.old_stamp = stamp;
          old_idx_next       = MY_IDX;
        end
      end else if (!tok_in.free_found) begin
        tok_next.free_found = 1'b1;
        free_idx_next       = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr_here) begin
        valid <= 1'b1;
      end else if (tok_in.active && tok_in.get && !tok_in.found && match && stale) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_idx_out <= found_idx_next;
    free_idx_out  <= free_idx_next;
    old_idx_out   <= old_idx_next;
    if (wr_here) begin
      key   <= wr.key;
      kind  <= wr.kind;
      stamp <= wr.stamp;
      life  <= wr.life;
    end
  end

endmodule
